FILE: src/head_pose_smoothing_filter_core_macros.svh
// Assertion macros shared by the head-pose smoothing filter RTL.
// Included by the top level; depends on nothing else.
`ifndef HEAD_POSE_SMOOTHING_FILTER_CORE_MACROS_SVH
`define HEAD_POSE_SMOOTHING_FILTER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HPSF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hpsf: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HPSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hpsf: next-cycle check failed");

`endif

FILE: src/hpsf_pkg.sv
// Package for the head-pose smoothing filter: widths, register codes,
// the exponential table, sequencer states and the serial-unit request types.
// Depends on nothing.
`default_nettype none

package hpsf_pkg;

	localparam int QUAT_FRAC_BITS = 14;
	localparam int POS_WIDTH      = 16;
	localparam int POS_EXTRA      = 8;
	localparam int HELD_W         = POS_WIDTH + POS_EXTRA;
	localparam int QUAT_W         = QUAT_FRAC_BITS + 2;
	localparam int QUAT_W_OUT     = QUAT_FRAC_BITS + 1;
	localparam int VEC_W          = QUAT_W + 1;
	localparam int REG_W          = 20;
	localparam int CFG_IDX_W      = 2;
	localparam int IN_TDATA_W     = 136;
	localparam int OUT_TDATA_W    = 112;

	localparam logic [REG_W-1:0] TAU_RESET  = REG_W'(55000);
	localparam logic [REG_W-1:0] MAXE_RESET = REG_W'(100000);

	localparam logic [CFG_IDX_W-1:0] CFG_TAU  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_MAXE = CFG_IDX_W'(1);

	// Serial divider geometry.
	localparam int DIV_REM_W   = 33;
	localparam int DIV_BITS_W  = 45;
	localparam int DIV_DEN_W   = 32;
	localparam int DIV_CNT_W   = 6;
	localparam int DIV_Q_W     = 17;
	localparam int RATIO_NUM_W = 33;
	localparam int RATIO_STEPS = 33;
	localparam int QDIV_STEPS  = 16;

	// Serial square-root geometry.
	localparam int SQRT_RAD_W  = 64;
	localparam int SQRT_ROOT_W = 32;
	localparam int SQRT_REM_W  = 35;
	localparam int SQRT_STEPS  = 32;
	localparam int SQRT_CNT_W  = 6;

	localparam int N2_W    = 33;
	localparam int P_W     = 25;
	localparam int EXP_W   = 24;
	localparam int GAIN_W  = 17;
	localparam int RATIO_W = 16;
	localparam int MUL_A_W = 26;
	localparam int MUL_B_W = 25;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	typedef struct packed {
		logic                   start;
		logic [DIV_REM_W-1:0]   rem_init;
		logic [DIV_BITS_W-1:0]  bits;
		logic [DIV_DEN_W-1:0]   den;
		logic [DIV_CNT_W-1:0]   count;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic               ovf;
		logic [DIV_Q_W-1:0] quot;
	} div_rsp_t;

	typedef struct packed {
		logic                  start;
		logic [SQRT_RAD_W-1:0] rad;
	} sqrt_req_t;

	typedef struct packed {
		logic                   done;
		logic [SQRT_ROOT_W-1:0] root;
	} sqrt_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RATIO,
		ST_RATIO_WAIT,
		ST_EXP,
		ST_GAIN,
		ST_POS,
		ST_SQ,
		ST_SQRT_GO,
		ST_SQRT_WAIT,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_SIGN,
		ST_DOT,
		ST_MIX,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		PASS_FROM,
		PASS_TO,
		PASS_MIX
	} pass_t;

	// exp(-2^(j-12)) in Q24 for bit j of the Q4.12 ratio.
	function automatic logic [EXP_W-1:0] exp_bit(input logic [3:0] j);
		logic [EXP_W-1:0] v;
		case (j)
			4'd0:    v = EXP_W'(16773120);
			4'd1:    v = EXP_W'(16769026);
			4'd2:    v = EXP_W'(16760840);
			4'd3:    v = EXP_W'(16744480);
			4'd4:    v = EXP_W'(16711808);
			4'd5:    v = EXP_W'(16646655);
			4'd6:    v = EXP_W'(16517109);
			4'd7:    v = EXP_W'(16261035);
			4'd8:    v = EXP_W'(15760736);
			4'd9:    v = EXP_W'(14805841);
			4'd10:   v = EXP_W'(13066109);
			4'd11:   v = EXP_W'(10175896);
			4'd12:   v = EXP_W'(6171993);
			4'd13:   v = EXP_W'(2270549);
			4'd14:   v = EXP_W'(307285);
			4'd15:   v = EXP_W'(5628);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

FILE: src/head_pose_smoothing_filter_core.sv
// Head-pose smoothing filter, top level: sequencer, shared multiplier and state.
// A restart or first sample goes straight to the result in the neutral pose; otherwise the time
// to a result is set by the bit-serial divider (33 steps for the gain ratio, 16 per quaternion
// component) and the 32-step square root, run 3 times (fewer when a quaternion is all zero).
// One sample is in flight; the input is ready in the cycle after the result loads.
// Reset (arst_n low, asynchronous) restores register defaults and neutral pose.
`default_nettype none
`include "head_pose_smoothing_filter_core_macros.svh"

module head_pose_smoothing_filter_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Sample input.
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// From bit 0: elapsed_us[20], pos_x, pos_y, pos_z, quat_x, quat_y, quat_z,
	// quat_w (16 each), then four zero pad bits.
	input  wire logic [hpsf_pkg::IN_TDATA_W-1:0]   s_tdata,
	// restart.
	input  wire logic                              s_tuser,
	// Filtered pose output.
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// From bit 0: smooth_pos_x, smooth_pos_y, smooth_pos_z, smooth_quat_x,
	// smooth_quat_y, smooth_quat_z (16 each), smooth_quat_w (15), one pad bit.
	output logic [hpsf_pkg::OUT_TDATA_W-1:0]       m_tdata,
	// Configuration writes.
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [hpsf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [hpsf_pkg::REG_W-1:0]        cfg_data
);
	import hpsf_pkg::*;

	localparam logic signed [QUAT_W-1:0] QUAT_ONE = QUAT_W'(1) << QUAT_FRAC_BITS;
	localparam logic [P_W-1:0]           P_ONE    = P_W'(1) << (P_W - 1);

	// Control and filter state.
	state_t                   state_q, state_d;
	pass_t                    pass_q;
	logic [1:0]               idx_q;
	logic [3:0]               jcnt_q;
	logic                     primed_q;
	logic [REG_W-1:0]         tau_q;
	logic [REG_W-1:0]         maxe_q;
	logic signed [HELD_W-1:0] hpos_q [3];
	logic signed [QUAT_W-1:0] hrot_q [4];
	logic                     m_tvalid_q;

	// Working registers of the current sample.
	logic [REG_W-1:0]            elapsed_q;
	logic signed [POS_WIDTH-1:0] tpos_q [3];
	logic signed [QUAT_W-1:0]    tquat_q [4];
	logic [RATIO_W-1:0]          ratio_q;
	logic [P_W-1:0]              p_q;
	logic [GAIN_W-1:0]           g_q;
	logic signed [VEC_W-1:0]     vec_q [4];
	logic signed [QUAT_W-1:0]    from_q [4];
	logic signed [QUAT_W-1:0]    to_q [4];
	logic signed [QUAT_W-1:0]    nq_q [4];
	logic [N2_W-1:0]             n2_q;
	logic [SQRT_ROOT_W-1:0]      len_q;
	logic signed [31:0]          dot_q;
	logic [OUT_TDATA_W-1:0]      m_tdata_q;

	div_req_t  div_req;
	div_rsp_t  div_rsp;
	sqrt_req_t sqrt_req;
	sqrt_rsp_t sqrt_rsp;

	hpsf_div_serial u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	hpsf_sqrt_serial u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sqrt_req),
		.rsp    (sqrt_rsp)
	);

	// Combinational datapath around the one shared multiplier.
	logic [REG_W-1:0]            elapsed_sat;
	logic [REG_W-1:0]            tau_eff;
	logic [RATIO_NUM_W-1:0]      ratio_num;
	logic signed [MUL_A_W-1:0]   mul_a;
	logic signed [MUL_B_W-1:0]   mul_b;
	logic signed [PROD_W-1:0]    prod;
	logic signed [PROD_W-1:0]    prod_rnd16;
	logic [PROD_W-1:0]           p_rnd;
	logic signed [HELD_W:0]      pos_diff;
	logic signed [QUAT_W-1:0]    to_sel;
	logic signed [VEC_W-1:0]     mix_diff;
	logic [VEC_W-1:0]            vec_mag;
	logic [DIV_BITS_W-1:0]       qnum;
	logic [QUAT_W-1:0]           q_clamp;
	logic signed [QUAT_W-1:0]    nq_val;
	logic signed [QUAT_W-1:0]    nq_fix [4];
	logic [P_W:0]                p_out_rnd;
	logic [GAIN_W:0]             g_full;
	logic [HELD_W:0]             pos_rnd [3];
	logic [POS_WIDTH-1:0]        pos_out [3];
	logic                        do_load;

	always_comb begin
		elapsed_sat = (elapsed_q < maxe_q) ? elapsed_q : maxe_q;
		tau_eff     = (tau_q == '0) ? REG_W'(1) : tau_q;
		ratio_num   = {1'b0, elapsed_sat, 12'b0} + RATIO_NUM_W'(tau_eff[REG_W-1:1]);

		pos_diff = {tpos_q[idx_q][POS_WIDTH-1], tpos_q[idx_q], POS_EXTRA'(0)}
		         - {hpos_q[idx_q][HELD_W-1], hpos_q[idx_q]};
		// Take the shorter arc: flip the target when the dot product is negative.
		to_sel   = dot_q[31] ? -to_q[idx_q] : to_q[idx_q];
		mix_diff = {to_sel[QUAT_W-1], to_sel} - {from_q[idx_q][QUAT_W-1], from_q[idx_q]};

		case (state_q)
			ST_EXP: begin
				mul_a = $signed({1'b0, p_q});
				mul_b = $signed({1'b0, exp_bit(jcnt_q)});
			end
			ST_POS: begin
				mul_a = MUL_A_W'(pos_diff);
				mul_b = $signed({(MUL_B_W - GAIN_W)'(0), g_q});
			end
			ST_SQ: begin
				mul_a = MUL_A_W'(vec_q[idx_q]);
				mul_b = MUL_B_W'(vec_q[idx_q]);
			end
			ST_DOT: begin
				mul_a = MUL_A_W'(from_q[idx_q]);
				mul_b = MUL_B_W'(to_q[idx_q]);
			end
			ST_MIX: begin
				mul_a = MUL_A_W'(mix_diff);
				mul_b = $signed({(MUL_B_W - GAIN_W)'(0), g_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod       = mul_a * mul_b;
		prod_rnd16 = (prod + PROD_W'(32768)) >>> 16;
		p_rnd      = prod + (PROD_W'(1) << (EXP_W - 1));

		// Gain alpha = 1 - exp(-r), Q16.
		p_out_rnd = {1'b0, p_q} + (P_W + 1)'(128);
		g_full    = (GAIN_W + 1)'(65536) - p_out_rnd[P_W:8];

		// Component division for normalization: (|v| << 29 + len / 2) / len.
		vec_mag = vec_q[idx_q][VEC_W-1] ? VEC_W'(-vec_q[idx_q]) : VEC_W'(vec_q[idx_q]);
		qnum    = {vec_mag[15:0], 29'b0} + DIV_BITS_W'(len_q[SQRT_ROOT_W-1:1]);
		q_clamp = (div_rsp.ovf || div_rsp.quot > DIV_Q_W'(QUAT_ONE))
		        ? QUAT_ONE : div_rsp.quot[QUAT_W-1:0];
		nq_val  = vec_q[idx_q][VEC_W-1] ? -$signed(q_clamp) : $signed(q_clamp);

		// Keep w non-negative by negating the whole quaternion.
		for (int i = 0; i < 4; i++) begin
			nq_fix[i] = nq_q[3][QUAT_W-1] ? -nq_q[i] : nq_q[i];
		end

		// Output translation: round half up to Q3.12 and saturate.
		for (int i = 0; i < 3; i++) begin
			pos_rnd[i] = {hpos_q[i][HELD_W-1], hpos_q[i]} + (HELD_W + 1)'(128);
			if (pos_rnd[i][HELD_W] != pos_rnd[i][HELD_W-1]) begin
				pos_out[i] = pos_rnd[i][HELD_W] ? {1'b1, (POS_WIDTH - 1)'(0)}
				                                : {1'b0, {(POS_WIDTH - 1){1'b1}}};
			end else begin
				pos_out[i] = pos_rnd[i][HELD_W-1:POS_EXTRA];
			end
		end

		do_load = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);
	end

	// Sequencer: next state and requests to the serial units.
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		div_req  = '0;
		sqrt_req = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = (s_tuser || !primed_q) ? ST_OUT : ST_RATIO;
				end
			end
			ST_RATIO: begin
				div_req.start    = 1'b1;
				div_req.rem_init = '0;
				div_req.bits     = {ratio_num, (DIV_BITS_W - RATIO_NUM_W)'(0)};
				div_req.den      = DIV_DEN_W'(tau_eff);
				div_req.count    = DIV_CNT_W'(RATIO_STEPS);
				state_d          = ST_RATIO_WAIT;
			end
			ST_RATIO_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_EXP;
				end
			end
			ST_EXP: begin
				if (jcnt_q == 4'd15) begin
					state_d = ST_GAIN;
				end
			end
			ST_GAIN: begin
				state_d = ST_POS;
			end
			ST_POS: begin
				if (idx_q == 2'd2) begin
					state_d = ST_SQ;
				end
			end
			ST_SQ: begin
				if (idx_q == 2'd3) begin
					state_d = ST_SQRT_GO;
				end
			end
			ST_SQRT_GO: begin
				if (n2_q == '0) begin
					state_d = ST_SIGN;
				end else begin
					sqrt_req.start = 1'b1;
					sqrt_req.rad   = {1'b0, n2_q, 30'b0};
					state_d        = ST_SQRT_WAIT;
				end
			end
			ST_SQRT_WAIT: begin
				if (sqrt_rsp.done) begin
					state_d = ST_DIV_GO;
				end
			end
			ST_DIV_GO: begin
				div_req.start    = 1'b1;
				div_req.rem_init = DIV_REM_W'(qnum[DIV_BITS_W-1:QDIV_STEPS]);
				div_req.bits     = {qnum[QDIV_STEPS-1:0], (DIV_BITS_W - QDIV_STEPS)'(0)};
				div_req.den      = len_q;
				div_req.count    = DIV_CNT_W'(QDIV_STEPS);
				state_d          = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					state_d = (idx_q == 2'd3) ? ST_SIGN : ST_DIV_GO;
				end
			end
			ST_SIGN: begin
				case (pass_q)
					PASS_FROM: state_d = ST_SQ;
					PASS_TO:   state_d = ST_DOT;
					default:   state_d = ST_OUT;
				endcase
			end
			ST_DOT: begin
				if (idx_q == 2'd3) begin
					state_d = ST_MIX;
				end
			end
			ST_MIX: begin
				if (idx_q == 2'd3) begin
					state_d = ST_SQ;
				end
			end
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control state, configuration and held pose.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pass_q     <= PASS_FROM;
			idx_q      <= '0;
			jcnt_q     <= '0;
			primed_q   <= 1'b0;
			tau_q      <= TAU_RESET;
			maxe_q     <= MAXE_RESET;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				hpos_q[i] <= '0;
			end
			for (int i = 0; i < 3; i++) begin
				hrot_q[i] <= '0;
			end
			hrot_q[3] <= QUAT_ONE;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_TAU:  tau_q  <= cfg_data;
					CFG_MAXE: maxe_q <= cfg_data;
					default:  ;
				endcase
			end
			// A new result replaces the old one in the same cycle it is taken.
			if (do_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					// Restart or first sample puts the filter in the neutral pose.
					if (s_tvalid && (s_tuser || !primed_q)) begin
						primed_q <= 1'b1;
						for (int i = 0; i < 3; i++) begin
							hpos_q[i] <= '0;
						end
						for (int i = 0; i < 3; i++) begin
							hrot_q[i] <= '0;
						end
						hrot_q[3] <= QUAT_ONE;
					end
				end
				ST_RATIO_WAIT: jcnt_q <= '0;
				ST_EXP:        jcnt_q <= jcnt_q + 1'b1;
				ST_GAIN:       idx_q  <= '0;
				ST_POS: begin
					hpos_q[idx_q] <= hpos_q[idx_q] + prod_rnd16[HELD_W-1:0];
					if (idx_q == 2'd2) begin
						idx_q  <= '0;
						pass_q <= PASS_FROM;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_SQ, ST_DOT: idx_q <= idx_q + 1'b1;
				ST_MIX: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == 2'd3) begin
						pass_q <= PASS_MIX;
					end
				end
				ST_DIV_WAIT: begin
					if (div_rsp.done) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_SIGN: begin
					case (pass_q)
						PASS_FROM: pass_q <= PASS_TO;
						PASS_MIX: begin
							for (int i = 0; i < 4; i++) begin
								hrot_q[i] <= nq_fix[i];
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	// Working registers; no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					elapsed_q <= s_tdata[REG_W-1:0];
					for (int i = 0; i < 3; i++) begin
						tpos_q[i] <= s_tdata[REG_W + POS_WIDTH*i +: POS_WIDTH];
					end
					for (int i = 0; i < 4; i++) begin
						tquat_q[i] <= s_tdata[REG_W + 3*POS_WIDTH + QUAT_W*i +: QUAT_W];
					end
				end
			end
			ST_RATIO_WAIT: begin
				if (div_rsp.done) begin
					ratio_q <= (div_rsp.ovf || div_rsp.quot[DIV_Q_W-1])
					         ? {RATIO_W{1'b1}} : div_rsp.quot[RATIO_W-1:0];
					p_q     <= P_ONE;
				end
			end
			ST_EXP: begin
				if (ratio_q[jcnt_q]) begin
					p_q <= p_rnd[EXP_W + P_W - 1:EXP_W];
				end
			end
			ST_GAIN: g_q <= g_full[GAIN_W-1:0];
			ST_POS: begin
				if (idx_q == 2'd2) begin
					for (int i = 0; i < 4; i++) begin
						vec_q[i] <= VEC_W'(hrot_q[i]);
					end
					n2_q <= '0;
				end
			end
			ST_SQ: n2_q <= n2_q + prod[N2_W-1:0];
			ST_SQRT_GO: begin
				// An all-zero quaternion normalizes to the identity.
				if (n2_q == '0) begin
					for (int i = 0; i < 3; i++) begin
						nq_q[i] <= '0;
					end
					nq_q[3] <= QUAT_ONE;
				end
			end
			ST_SQRT_WAIT: begin
				if (sqrt_rsp.done) begin
					len_q <= sqrt_rsp.root;
				end
			end
			ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					nq_q[idx_q] <= nq_val;
				end
			end
			ST_SIGN: begin
				case (pass_q)
					PASS_FROM: begin
						for (int i = 0; i < 4; i++) begin
							from_q[i] <= nq_fix[i];
							vec_q[i]  <= VEC_W'(tquat_q[i]);
						end
						n2_q <= '0;
					end
					PASS_TO: begin
						for (int i = 0; i < 4; i++) begin
							to_q[i] <= nq_fix[i];
						end
						dot_q <= '0;
					end
					default: ;
				endcase
			end
			ST_DOT: dot_q <= dot_q + prod[31:0];
			ST_MIX: begin
				vec_q[idx_q] <= VEC_W'(from_q[idx_q]) + prod_rnd16[VEC_W-1:0];
				if (idx_q == 2'd3) begin
					n2_q <= '0;
				end
			end
			ST_OUT: begin
				if (do_load) begin
					m_tdata_q <= {1'b0, hrot_q[3][QUAT_W_OUT-1:0], hrot_q[2], hrot_q[1],
					              hrot_q[0], pos_out[2], pos_out[1], pos_out[0]};
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		m_tvalid  = m_tvalid_q;
		m_tdata   = m_tdata_q;
		cfg_ready = 1'b1;
	end

	`HPSF_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, s_tvalid && s_tready, state_q != ST_IDLE)
	`HPSF_ASSERT_IMPLIES(a_out_w_unit, clk, arst_n, m_tvalid, m_tdata[110:96] <= 15'd16384)
	`HPSF_ASSERT_IMPLIES(a_sqrt_done_waited, clk, arst_n, sqrt_rsp.done, state_q == ST_SQRT_WAIT)
	`HPSF_ASSERT_IMPLIES(a_div_done_waited, clk, arst_n, div_rsp.done, state_q == ST_RATIO_WAIT || state_q == ST_DIV_WAIT)

endmodule

`default_nettype wire

FILE: src/hpsf_div_serial.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on hpsf_pkg for the request and response types.
`default_nettype none

module hpsf_div_serial (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire hpsf_pkg::div_req_t req,
	output hpsf_pkg::div_rsp_t    rsp
);
	import hpsf_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [DIV_REM_W-1:0]  rem_q;
	logic [DIV_BITS_W-1:0] bits_q;
	logic [DIV_DEN_W-1:0]  den_q;
	logic [DIV_Q_W-1:0]    quot_q;
	logic                  ovf_q;
	logic [DIV_REM_W-1:0]  rem_sh;
	logic [DIV_REM_W-1:0]  rem_sub;
	logic                  fits;

	// The remainder stays below the divisor, so one shifted-in bit never
	// overflows the remainder register.
	always_comb begin
		rem_sh  = {rem_q[DIV_REM_W-2:0], bits_q[DIV_BITS_W-1]};
		fits    = rem_sh >= {1'b0, den_q};
		rem_sub = rem_sh - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.count;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.rem_init;
			bits_q <= req.bits;
			den_q  <= req.den;
			quot_q <= '0;
			ovf_q  <= 1'b0;
		end else if (busy_q) begin
			rem_q  <= fits ? rem_sub : rem_sh;
			bits_q <= {bits_q[DIV_BITS_W-2:0], 1'b0};
			quot_q <= {quot_q[DIV_Q_W-2:0], fits};
			ovf_q  <= ovf_q | quot_q[DIV_Q_W-1];
		end
	end

	always_comb begin
		rsp.done = done_q;
		rsp.ovf  = ovf_q;
		rsp.quot = quot_q;
	end

endmodule

`default_nettype wire

FILE: src/hpsf_sqrt_serial.sv
// Digit-serial integer square root, two radicand bits per cycle.
// Depends on hpsf_pkg for the request and response types.
`default_nettype none

module hpsf_sqrt_serial (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire hpsf_pkg::sqrt_req_t req,
	output hpsf_pkg::sqrt_rsp_t    rsp
);
	import hpsf_pkg::*;

	logic                   busy_q;
	logic                   done_q;
	logic [SQRT_CNT_W-1:0]  cnt_q;
	logic [SQRT_RAD_W-1:0]  rad_q;
	logic [SQRT_REM_W-1:0]  rem_q;
	logic [SQRT_ROOT_W-1:0] root_q;
	logic [SQRT_REM_W-1:0]  rem_sh;
	logic [SQRT_REM_W-1:0]  trial;
	logic                   fits;

	// The remainder never exceeds twice the partial root.
	always_comb begin
		rem_sh = {rem_q[SQRT_REM_W-3:0], rad_q[SQRT_RAD_W-1:SQRT_RAD_W-2]};
		trial  = {1'b0, root_q, 2'b01};
		fits   = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= SQRT_CNT_W'(SQRT_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == SQRT_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rad_q  <= req.rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[SQRT_RAD_W-3:0], 2'b00};
			rem_q  <= fits ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[SQRT_ROOT_W-2:0], fits};
		end
	end

	always_comb begin
		rsp.done = done_q;
		rsp.root = root_q;
	end

endmodule

`default_nettype wire
